/* design/x12rsc_pkg.sv */
// Package for the X12 835 remittance segment checker.
// Holds segment and role codes, error kinds and the per-segment rule table.
// No dependencies.
package x12rsc_pkg;

    localparam int SEG_W   = 5;
    localparam int CNT_W   = 6;
    localparam int ERR_W   = 3;
    localparam int ROLE_W  = 4;
    localparam int NROLES  = 9;
    localparam int NMAND   = 7;

    typedef logic [SEG_W-1:0]  seg_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ROLE_W-1:0] role_t;
    typedef logic [NROLES-1:0] role_mask_t;
    typedef logic [NMAND-1:0]  mand_mask_t;

    // Segment tag codes
    localparam seg_t SEG_ISA = 5'd0;
    localparam seg_t SEG_GS  = 5'd1;
    localparam seg_t SEG_ST  = 5'd2;
    localparam seg_t SEG_N1  = 5'd3;
    localparam seg_t SEG_SE  = 5'd4;
    localparam seg_t SEG_GE  = 5'd5;
    localparam seg_t SEG_IEA = 5'd6;
    localparam seg_t SEG_LX  = 5'd16;
    localparam seg_t SEG_CLP = 5'd19;
    localparam seg_t SEG_SVC = 5'd26;
    localparam seg_t SEG_PLB = 5'd28;
    localparam seg_t SEG_NUM = 5'd29;   // first unrecognised code

    // Loop roles
    localparam role_t ROLE_ROOT  = 4'd0;
    localparam role_t ROLE_ICHG  = 4'd1;
    localparam role_t ROLE_GRP   = 4'd2;
    localparam role_t ROLE_TXN   = 4'd3;
    localparam role_t ROLE_PAYER = 4'd4;
    localparam role_t ROLE_PAYEE = 4'd5;
    localparam role_t ROLE_HDR   = 4'd6;
    localparam role_t ROLE_CLM   = 4'd7;
    localparam role_t ROLE_SVC   = 4'd8;

    localparam role_mask_t RB_ROOT  = role_mask_t'(1) << ROLE_ROOT;
    localparam role_mask_t RB_TXN   = role_mask_t'(1) << ROLE_TXN;
    localparam role_mask_t RB_PAYER = role_mask_t'(1) << ROLE_PAYER;
    localparam role_mask_t RB_PAYEE = role_mask_t'(1) << ROLE_PAYEE;
    localparam role_mask_t RB_HDR   = role_mask_t'(1) << ROLE_HDR;
    localparam role_mask_t RB_CLM   = role_mask_t'(1) << ROLE_CLM;
    localparam role_mask_t RB_SVC   = role_mask_t'(1) << ROLE_SVC;

    typedef enum logic [1:0] {
        TK_NONE = 2'd0,
        TK_SE   = 2'd1,
        TK_GE   = 2'd2,
        TK_IEA  = 2'd3
    } trailer_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_MISPLACED = 3'd1,
        ERR_COUNT     = 3'd2,
        ERR_NOT_FIRST = 3'd3,
        ERR_UNKNOWN   = 3'd4,
        ERR_MISSING   = 3'd5,
        ERR_IGNORED   = 3'd6
    } err_t;

    typedef struct packed {
        cnt_t       lo;
        cnt_t       hi;
        role_mask_t roles;  // zero: placement decided by a special rule
    } seg_rule_t;

    function automatic seg_rule_t seg_rule(input seg_t t);
        seg_rule_t r;
        r = '{lo: 6'd0, hi: 6'd0, roles: '0};
        case (t)
            5'd0:  r = '{6'd16, 6'd16, RB_ROOT};
            5'd1:  r = '{6'd8,  6'd8,  role_mask_t'(0)};
            5'd2:  r = '{6'd2,  6'd2,  role_mask_t'(0)};
            5'd3:  r = '{6'd2,  6'd6,  RB_TXN | RB_PAYER};
            5'd4:  r = '{6'd2,  6'd2,  role_mask_t'(0)};
            5'd5:  r = '{6'd2,  6'd2,  role_mask_t'(0)};
            5'd6:  r = '{6'd2,  6'd2,  role_mask_t'(0)};
            5'd7:  r = '{6'd16, 6'd21, RB_TXN};
            5'd8:  r = '{6'd3,  6'd4,  RB_TXN};
            5'd9:  r = '{6'd2,  6'd21, RB_TXN};
            5'd10: r = '{6'd1,  6'd4,  RB_PAYER | RB_PAYEE | RB_TXN | RB_CLM | RB_SVC};
            5'd11: r = '{6'd1,  6'd4,  RB_TXN | RB_CLM | RB_SVC};
            5'd12: r = '{6'd1,  6'd2,  RB_PAYER | RB_PAYEE};
            5'd13: r = '{6'd1,  6'd3,  RB_PAYER | RB_PAYEE};
            5'd14: r = '{6'd1,  6'd9,  RB_PAYER | RB_CLM};
            5'd15: r = '{6'd1,  6'd3,  RB_PAYEE};
            5'd16: r = '{6'd1,  6'd1,  RB_PAYEE};
            5'd17: r = '{6'd1,  6'd19, RB_HDR};
            5'd18: r = '{6'd1,  6'd24, RB_HDR};
            5'd19: r = '{6'd3,  6'd14, RB_HDR | RB_CLM | RB_SVC};
            5'd20: r = '{6'd2,  6'd11, RB_CLM};
            5'd21: r = '{6'd1,  6'd24, RB_CLM};
            5'd22: r = '{6'd1,  6'd9,  RB_CLM};
            5'd23: r = '{6'd3,  6'd19, RB_CLM | RB_SVC};
            5'd24: r = '{6'd2,  6'd3,  RB_CLM | RB_SVC};
            5'd25: r = '{6'd2,  6'd4,  RB_CLM | RB_SVC};
            5'd26: r = '{6'd3,  6'd7,  RB_CLM | RB_SVC};
            5'd27: r = '{6'd2,  6'd2,  RB_SVC};
            5'd28: r = '{6'd4,  6'd14, RB_CLM | RB_SVC | RB_TXN | RB_PAYEE};
            default: r = '{lo: 6'd0, hi: 6'd0, roles: '0};
        endcase
        return r;
    endfunction

endpackage

/* design/x12rsc_if.sv */
// Handshake interfaces for the segment checker: segment items in, results out.
// Depends on x12rsc_pkg.
interface x12rsc_seg_if;
    import x12rsc_pkg::*;

    logic valid;
    logic ready;
    logic action;
    seg_t segment_type;
    cnt_t element_count;

    modport source (output valid, action, segment_type, element_count, input ready);
    modport sink   (input valid, action, segment_type, element_count, output ready);
endinterface

interface x12rsc_res_if;
    import x12rsc_pkg::*;

    logic        valid;
    logic        ready;
    logic        accepted;
    logic [ERR_W-1:0] error_kind;
    seg_t        error_segment;
    role_t       attach_parent;
    logic        is_final;

    modport source (output valid, accepted, error_kind, error_segment, attach_parent,
                    is_final, input ready);
    modport sink   (input valid, accepted, error_kind, error_segment, attach_parent,
                    is_final, output ready);
endinterface

/* design/x12_remittance_segment_checker.sv */
// X12 835 remittance segment structure checker, top level.
// Depends on x12rsc_pkg and the interfaces in x12rsc_if.sv.
//
// Takes one tokenised segment (type code and element count) or an
// end-of-document marker per transaction and returns exactly one result per
// item. One item is accepted every clock cycle while results are taken; an
// accepted item lands in the input register, and its result in the result
// register once the step between them advances, which a stalled full result
// register delays. All checking is done in the single step between the two
// registers, where the loop state is read and updated, so consecutive items
// see each other's effects with no bubble. A full result register with the
// sink stalled holds back the input register and then the input channel.
module x12_remittance_segment_checker (
    input  logic               clk,
    input  logic               rst_n,
    x12rsc_seg_if.sink         item,
    x12rsc_res_if.source       result
);
    import x12rsc_pkg::*;

    // input register
    logic       in_valid_reg;
    logic       in_action_reg;
    seg_t       in_type_reg;
    cnt_t       in_cnt_reg;

    // loop state
    role_t      loop_role_reg,    loop_role_next;
    trailer_t   trailer_reg,      trailer_next;
    logic       header_seen_reg,  header_seen_next;
    logic       txn_seen_reg,     txn_seen_next;
    mand_mask_t mand_mask_reg,    mand_mask_next;
    logic       failed_reg,       failed_next;

    // result register
    logic       out_valid_reg;
    logic       out_acc_reg,      out_acc_next;
    err_t       out_err_reg,      out_err_next;
    seg_t       out_seg_reg,      out_seg_next;
    role_t      out_parent_reg,   out_parent_next;
    logic       out_final_reg,    out_final_next;

    logic       advance;
    seg_rule_t  rule;
    logic       placed;
    logic       cnt_ok;
    logic [2:0] miss_idx;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    assign rule   = seg_rule(in_type_reg);
    assign cnt_ok = (in_cnt_reg >= rule.lo) && (in_cnt_reg <= rule.hi);

    always_comb
    begin
        placed = rule.roles[loop_role_reg];
        unique case (in_type_reg)
            SEG_GS:  placed = (loop_role_reg == ROLE_ICHG) || (trailer_reg == TK_GE);
            SEG_ST:  placed = (loop_role_reg == ROLE_GRP) || (trailer_reg == TK_SE);
            SEG_SE:  placed = txn_seen_reg && (trailer_reg != TK_IEA);
            SEG_GE:  placed = (trailer_reg == TK_SE);
            SEG_IEA: placed = (loop_role_reg == ROLE_GRP) || (trailer_reg == TK_GE);
            SEG_CLP: placed = header_seen_reg && placed;
            default: ;
        endcase
    end

    // lowest missing mandatory type
    always_comb
    begin
        miss_idx = '0;
        for (int i = NMAND - 1; i >= 0; i--)
        begin
            if (!mand_mask_reg[i])
                miss_idx = 3'(i);
        end
    end

    always_comb
    begin
        loop_role_next   = loop_role_reg;
        trailer_next     = trailer_reg;
        header_seen_next = header_seen_reg;
        txn_seen_next    = txn_seen_reg;
        mand_mask_next   = mand_mask_reg;
        failed_next      = failed_reg;

        out_acc_next    = 1'b0;
        out_err_next    = ERR_NONE;
        out_seg_next    = in_type_reg;
        out_parent_next = ROLE_ROOT;
        out_final_next  = in_action_reg;

        if (in_action_reg)
        begin
            out_seg_next = '0;
            if (failed_reg)
                out_err_next = ERR_IGNORED;
            else if (mand_mask_reg != '1)
            begin
                out_err_next = ERR_MISSING;
                out_seg_next = seg_t'(miss_idx);
                failed_next  = 1'b1;
            end
            else
                out_acc_next = 1'b1;
        end
        else if (failed_reg)
            out_err_next = ERR_IGNORED;
        else if (in_type_reg != SEG_ISA && loop_role_reg == ROLE_ROOT)
        begin
            out_err_next = ERR_NOT_FIRST;
            failed_next  = 1'b1;
        end
        else if (in_type_reg >= SEG_NUM)
        begin
            out_err_next = ERR_UNKNOWN;
            failed_next  = 1'b1;
        end
        else if (!placed)
        begin
            out_err_next = ERR_MISPLACED;
            failed_next  = 1'b1;
        end
        else if (!cnt_ok)
        begin
            out_err_next = ERR_COUNT;
            failed_next  = 1'b1;
        end
        else
        begin
            out_acc_next    = 1'b1;
            out_seg_next    = '0;
            out_parent_next = loop_role_reg;
            if (in_type_reg < SEG_NUM && in_type_reg <= SEG_IEA)
                mand_mask_next = mand_mask_reg | (mand_mask_t'(1) << in_type_reg[2:0]);
            unique case (in_type_reg)
                SEG_ISA:
                begin
                    out_parent_next = ROLE_ROOT;
                    loop_role_next  = ROLE_ICHG;
                end
                SEG_GS:  loop_role_next = ROLE_GRP;
                SEG_ST:
                begin
                    loop_role_next = ROLE_TXN;
                    txn_seen_next  = 1'b1;
                end
                SEG_N1:
                begin
                    if (loop_role_reg == ROLE_TXN)
                    begin
                        out_parent_next = ROLE_TXN;
                        loop_role_next  = ROLE_PAYER;
                    end
                    else
                    begin
                        out_parent_next = ROLE_PAYER;
                        loop_role_next  = ROLE_PAYEE;
                    end
                end
                SEG_SE:
                begin
                    out_parent_next = ROLE_TXN;
                    loop_role_next  = ROLE_TXN;
                    trailer_next    = TK_SE;
                end
                SEG_GE:
                begin
                    out_parent_next = ROLE_GRP;
                    loop_role_next  = ROLE_GRP;
                    trailer_next    = TK_GE;
                end
                SEG_IEA:
                begin
                    out_parent_next = ROLE_ICHG;
                    loop_role_next  = ROLE_ICHG;
                    trailer_next    = TK_IEA;
                end
                SEG_LX:
                begin
                    loop_role_next   = ROLE_HDR;
                    header_seen_next = 1'b1;
                end
                SEG_CLP:
                begin
                    out_parent_next = ROLE_HDR;
                    loop_role_next  = ROLE_CLM;
                end
                SEG_SVC:
                begin
                    out_parent_next = ROLE_CLM;
                    loop_role_next  = ROLE_SVC;
                end
                SEG_PLB:
                begin
                    out_parent_next = ROLE_TXN;
                    loop_role_next  = ROLE_TXN;
                end
                default: ;
            endcase
        end
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            loop_role_reg   <= ROLE_ROOT;
            trailer_reg     <= TK_NONE;
            header_seen_reg <= 1'b0;
            txn_seen_reg    <= 1'b0;
            mand_mask_reg   <= '0;
            failed_reg      <= 1'b0;
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                loop_role_reg   <= loop_role_next;
                trailer_reg     <= trailer_next;
                header_seen_reg <= header_seen_next;
                txn_seen_reg    <= txn_seen_next;
                mand_mask_reg   <= mand_mask_next;
                failed_reg      <= failed_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_action_reg <= item.action;
            in_type_reg   <= item.segment_type;
            in_cnt_reg    <= item.element_count;
        end
        if (advance)
        begin
            out_acc_reg    <= out_acc_next;
            out_err_reg    <= out_err_next;
            out_seg_reg    <= out_seg_next;
            out_parent_reg <= out_parent_next;
            out_final_reg  <= out_final_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.accepted      = out_acc_reg;
    assign result.error_kind    = out_err_reg;
    assign result.error_segment = out_seg_reg;
    assign result.attach_parent = out_parent_reg;
    assign result.is_final      = out_final_reg;

`ifndef SYNTH
    // failure is sticky
    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |=> failed_reg)
        else $error("failure flag cleared");

    // once a segment is accepted, the interchange header must have been seen
    a_isa_first: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_acc_reg && !out_final_reg) |-> mand_mask_reg[0])
        else $error("segment accepted without interchange header");

    // an accepted result carries no error
    a_acc_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_acc_reg) |-> (out_err_reg == ERR_NONE && out_seg_reg == '0))
        else $error("accepted result with error fields set");

    // a stalled result holds while the input register waits
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> ($stable(out_err_reg) && $stable(loop_role_reg)))
        else $error("result or state changed under stall");

    // loop role stays within the defined roles
    a_role_range: assert property (@(posedge clk) disable iff (!rst_n)
        loop_role_reg <= ROLE_SVC)
        else $error("loop role out of range");
`endif

endmodule
